FILE: hw/rtl/focus_break_cycle_timer_macros.svh
// ----------------------------------------------------------------------------
// focus_break_cycle_timer assertion macros
// shared property wrappers, sampled on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef FOCUS_BREAK_CYCLE_TIMER_MACROS_SVH
`define FOCUS_BREAK_CYCLE_TIMER_MACROS_SVH

// same-cycle implication
`define FBCT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fbct: same-cycle check failed");

// next-cycle implication
`define FBCT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fbct: next-cycle check failed");

`endif

FILE: hw/rtl/fbct_pkg.sv
// ----------------------------------------------------------------------------
// fbct_pkg
// types, command codes, reset values and helpers of the focus/break timer
// ----------------------------------------------------------------------------
package fbct_pkg;

	localparam int unsigned MS_W    = 24;
	localparam int unsigned TICK_W  = 16;
	localparam int unsigned SET_W   = 4;
	localparam int unsigned DAY_W   = 16;
	localparam int unsigned SEC_W   = 15;
	localparam int unsigned CMD_W   = 3;
	localparam int unsigned CODE_W  = 2;
	localparam int unsigned CFG_IDX_W = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_TAP   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SKIP  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RESET = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FOCUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SETS  = 2'd3;

	// phase codes as seen on the result port
	localparam logic [CODE_W-1:0] CODE_IDLE  = 2'd0;
	localparam logic [CODE_W-1:0] CODE_FOCUS = 2'd1;
	localparam logic [CODE_W-1:0] CODE_BREAK = 2'd2;

	localparam logic [MS_W-1:0]  RST_FOCUS_MS = 24'd1500000;
	localparam logic [MS_W-1:0]  RST_SHORT_MS = 24'd300000;
	localparam logic [MS_W-1:0]  RST_LONG_MS  = 24'd900000;
	localparam logic [SET_W-1:0] RST_SETS     = 4'd4;

	localparam logic [SET_W-1:0] SET_MAX = '1;
	localparam logic [DAY_W-1:0] DAY_MAX = '1;

	// ceil(ms / 1000) as ((ms + 999) * RECIP) >> SHIFT, exact below 2**25
	localparam logic [MS_W:0]   SEC_ROUND = 25'd999;
	localparam int unsigned     SEC_SHIFT = 35;
	localparam int unsigned     RECIP_W   = 26;
	localparam logic [RECIP_W-1:0] SEC_RECIP = 26'd34359739;
	localparam int unsigned     PROD_W    = MS_W + 1 + RECIP_W;

	typedef enum logic [2:0] {
		PHASE_IDLE  = 3'b001,
		PHASE_FOCUS = 3'b010,
		PHASE_BREAK = 3'b100
	} phase_t;

	typedef struct packed {
		logic [MS_W-1:0]  focus_len;
		logic [MS_W-1:0]  short_break_ms;
		logic [MS_W-1:0]  long_break_ms;
		logic [SET_W-1:0] sessions_per_set;
	} cfg_t;

	typedef struct packed {
		phase_t           phase;
		logic             paused;
		logic             long_brk;
		logic [MS_W-1:0]  time_left;
		logic [MS_W-1:0]  duration;
		logic [SET_W-1:0] set_pos;
		logic [DAY_W-1:0] day_total;
		logic             ended;
	} stat_t;

	function automatic logic [CODE_W-1:0] phase_code(input phase_t ph);
		logic [CODE_W-1:0] code;
		unique case (ph)
			PHASE_FOCUS: code = CODE_FOCUS;
			PHASE_BREAK: code = CODE_BREAK;
			default:     code = CODE_IDLE;
		endcase
		return code;
	endfunction

endpackage

FILE: hw/rtl/focus_break_cycle_timer.sv
// ----------------------------------------------------------------------------
// focus_break_cycle_timer
// idle/focus/break phase timer driven by tick and user command beats
// ----------------------------------------------------------------------------
// One command beat is taken every clock cycle while the result side keeps
// up; each beat gives exactly one result beat, presented on the result port
// after passing the input register, the phase update and the seconds rounding
// register. The whole command update is combinational against the phase
// registers, so nothing limits the rate but out_stall: in_stall rises only
// when all three stages hold beats and the result is held. Register writes
// apply when a phase is next loaded; the running phase keeps its length.
module focus_break_cycle_timer import fbct_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MS_W-1:0]      cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CMD_W-1:0]     command,
	input  logic [TICK_W-1:0]    elapsed_ms,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CODE_W-1:0]    phase_now,
	output logic                 is_paused,
	output logic                 is_long_break,
	output logic [MS_W-1:0]      remaining_ms,
	output logic [SEC_W-1:0]     remaining_seconds,
	output logic [MS_W-1:0]      duration_ms,
	output logic [SET_W-1:0]     set_position,
	output logic [DAY_W-1:0]     sessions_today,
	output logic                 session_ended
);

	cfg_t              cfg_q;
	logic              valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [TICK_W-1:0] elapsed_s1;
	logic              take_s1;
	logic              adv_s2;
	logic              valid_s2;
	logic              take_s3;
	stat_t             stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.focus_len        <= RST_FOCUS_MS;
			cfg_q.short_break_ms   <= RST_SHORT_MS;
			cfg_q.long_break_ms    <= RST_LONG_MS;
			cfg_q.sessions_per_set <= RST_SETS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FOCUS: cfg_q.focus_len        <= cfg_data;
				REG_SHORT: cfg_q.short_break_ms   <= cfg_data;
				REG_LONG:  cfg_q.long_break_ms    <= cfg_data;
				REG_SETS:  cfg_q.sessions_per_set <= cfg_data[SET_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign take_s1  = !valid_s1 || adv_s2;
	assign in_stall = !take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_s1) begin
			valid_s1 <= in_valid;
		end
	end

	// command beat register
	always_ff @(posedge clk) begin
		if (take_s1 && in_valid) begin
			cmd_s1     <= command;
			elapsed_s1 <= elapsed_ms;
		end
	end

	fbct_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.valid_s1   (valid_s1),
		.cmd_s1     (cmd_s1),
		.elapsed_s1 (elapsed_s1),
		.take_s3    (take_s3),
		.adv_s2     (adv_s2),
		.valid_s2   (valid_s2),
		.stat       (stat)
	);

	fbct_out_stage u_out (
		.clk               (clk),
		.arst_n            (arst_n),
		.valid_s2          (valid_s2),
		.stat              (stat),
		.out_stall         (out_stall),
		.take_s3           (take_s3),
		.out_valid         (out_valid),
		.phase_now         (phase_now),
		.is_paused         (is_paused),
		.is_long_break     (is_long_break),
		.remaining_ms      (remaining_ms),
		.remaining_seconds (remaining_seconds),
		.duration_ms       (duration_ms),
		.set_position      (set_position),
		.sessions_today    (sessions_today),
		.session_ended     (session_ended)
	);

endmodule

FILE: hw/rtl/fbct_core.sv
// ----------------------------------------------------------------------------
// fbct_core
// phase state registers and the combinational command update
`include "focus_break_cycle_timer_macros.svh"

module fbct_core import fbct_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              valid_s1,
	input  logic [CMD_W-1:0]  cmd_s1,
	input  logic [TICK_W-1:0] elapsed_s1,
	input  logic              take_s3,
	output logic              adv_s2,
	output logic              valid_s2,
	output stat_t             stat
);

	phase_t           phase_q, phase_d;
	logic             pause_q, pause_d;
	logic             long_q, long_d;
	logic [MS_W-1:0]  len_q, len_d;
	logic [MS_W-1:0]  left_q, left_d;
	logic [SET_W-1:0] set_q, set_d;
	logic [DAY_W-1:0] day_q, day_d;
	logic             ended_q, ended_d;
	logic             valid_q;
	logic [MS_W-1:0]  dt;
	logic [SET_W-1:0] set_inc;
	logic             long_next;
	logic             fire;

	assign adv_s2 = !valid_q || take_s3;
	assign fire   = valid_s1 && adv_s2;
	assign dt     = {{(MS_W-TICK_W){1'b0}}, elapsed_s1};
	assign set_inc   = (set_q != SET_MAX) ? set_q + 1'b1 : set_q;
	assign long_next = (set_inc >= cfg.sessions_per_set);

	always_comb begin
		phase_d = phase_q;
		pause_d = pause_q;
		long_d  = long_q;
		len_d   = len_q;
		left_d  = left_q;
		set_d   = set_q;
		day_d   = day_q;
		ended_d = 1'b0;
		unique case (cmd_s1)
			CMD_TICK: begin
				if (phase_q != PHASE_IDLE && !pause_q) begin
					if (left_q <= dt) begin
						ended_d = 1'b1;
						if (phase_q == PHASE_FOCUS) begin
							if (day_q != DAY_MAX) day_d = day_q + 1'b1;
							set_d   = set_inc;
							long_d  = long_next;
							phase_d = PHASE_BREAK;
							pause_d = 1'b0;
							len_d   = long_next ? cfg.long_break_ms : cfg.short_break_ms;
							left_d  = long_next ? cfg.long_break_ms : cfg.short_break_ms;
						end else begin
							if (long_q) begin
								set_d  = '0;
								long_d = 1'b0;
							end
							phase_d = PHASE_IDLE;
							pause_d = 1'b0;
							len_d   = cfg.focus_len;
							left_d  = cfg.focus_len;
						end
					end else begin
						left_d = left_q - dt;
					end
				end
			end
			CMD_TAP: begin
				if (phase_q == PHASE_IDLE) begin
					phase_d = PHASE_FOCUS;
					pause_d = 1'b0;
				end else begin
					pause_d = !pause_q;
				end
			end
			CMD_SKIP: begin
				if (phase_q != PHASE_IDLE) begin
					// a long break abandoned early still closes the set
					if (phase_q == PHASE_BREAK && long_q) begin
						set_d  = '0;
						long_d = 1'b0;
					end
					phase_d = PHASE_IDLE;
					pause_d = 1'b0;
					len_d   = cfg.focus_len;
					left_d  = cfg.focus_len;
				end
			end
			CMD_RESET: begin
				left_d = len_q;
				if (phase_q != PHASE_IDLE) pause_d = 1'b1;
			end
			CMD_CLEAR: begin
				day_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_IDLE;
			pause_q <= 1'b0;
			long_q  <= 1'b0;
			len_q   <= RST_FOCUS_MS;
			left_q  <= RST_FOCUS_MS;
			set_q   <= '0;
			day_q   <= '0;
			ended_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (adv_s2) valid_q <= valid_s1;
			if (fire) begin
				phase_q <= phase_d;
				pause_q <= pause_d;
				long_q  <= long_d;
				len_q   <= len_d;
				left_q  <= left_d;
				set_q   <= set_d;
				day_q   <= day_d;
				ended_q <= ended_d;
			end
		end
	end

	assign valid_s2       = valid_q;
	assign stat.phase     = phase_q;
	assign stat.paused    = pause_q;
	assign stat.long_brk  = long_q;
	assign stat.time_left = left_q;
	assign stat.duration  = len_q;
	assign stat.set_pos   = set_q;
	assign stat.day_total = day_q;
	assign stat.ended     = ended_q;

	`FBCT_ASSERT_NOW(a_idle_never_paused, phase_q == PHASE_IDLE, !pause_q)
	`FBCT_ASSERT_NOW(a_long_only_in_break, long_q, phase_q == PHASE_BREAK)
	`FBCT_ASSERT_NOW(a_left_within_length, 1'b1, left_q <= len_q)
	`FBCT_ASSERT_NEXT(a_ended_only_on_tick, fire && cmd_s1 != CMD_TICK, !ended_q)

endmodule

FILE: hw/rtl/fbct_out_stage.sv
// ----------------------------------------------------------------------------
// fbct_out_stage
// result register with rounding of remaining time to whole seconds
// ----------------------------------------------------------------------------
module fbct_out_stage import fbct_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s2,
	input  stat_t             stat,
	input  logic              out_stall,
	output logic              take_s3,
	output logic              out_valid,
	output logic [CODE_W-1:0] phase_now,
	output logic              is_paused,
	output logic              is_long_break,
	output logic [MS_W-1:0]   remaining_ms,
	output logic [SEC_W-1:0]  remaining_seconds,
	output logic [MS_W-1:0]   duration_ms,
	output logic [SET_W-1:0]  set_position,
	output logic [DAY_W-1:0]  sessions_today,
	output logic              session_ended
);

	logic              valid_s3;
	logic [MS_W:0]     num;
	logic [PROD_W-1:0] prod;

	// ceiling divide by 1000 through a reciprocal multiply
	assign num  = {1'b0, stat.time_left} + SEC_ROUND;
	assign prod = {{RECIP_W{1'b0}}, num} * {{(MS_W+1){1'b0}}, SEC_RECIP};

	assign take_s3 = !valid_s3 || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (take_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s3 && valid_s2) begin
			phase_now         <= phase_code(stat.phase);
			is_paused         <= stat.paused;
			is_long_break     <= stat.long_brk;
			remaining_ms      <= stat.time_left;
			remaining_seconds <= prod[SEC_SHIFT+SEC_W-1:SEC_SHIFT];
			duration_ms       <= stat.duration;
			set_position      <= stat.set_pos;
			sessions_today    <= stat.day_total;
			session_ended     <= stat.ended;
		end
	end

	assign out_valid = valid_s3;

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// focus_break_cycle_timer testbench
// drives command beats with random gaps, stalls the result side at random and
// checks every result beat against a cycle-free model of the phase timer
// ----------------------------------------------------------------------------
module testbench;
	import fbct_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned PRINT_LIMIT = 100;

	typedef struct packed {
		logic [CODE_W-1:0] phase;
		logic              paused;
		logic              long_brk;
		logic [MS_W-1:0]   left_ms;
		logic [SEC_W-1:0]  left_sec;
		logic [MS_W-1:0]   length_ms;
		logic [SET_W-1:0]  set_pos;
		logic [DAY_W-1:0]  day_cnt;
		logic              ended;
	} timer_view_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [MS_W-1:0]      cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [CMD_W-1:0]     command;
	logic [TICK_W-1:0]    elapsed_ms;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [CODE_W-1:0]    phase_now;
	logic                 is_paused;
	logic                 is_long_break;
	logic [MS_W-1:0]      remaining_ms;
	logic [SEC_W-1:0]     remaining_seconds;
	logic [MS_W-1:0]      duration_ms;
	logic [SET_W-1:0]     set_position;
	logic [DAY_W-1:0]     sessions_today;
	logic                 session_ended;

	// model of the timer: configuration and phase state
	logic [MS_W-1:0]   focus_len;
	logic [MS_W-1:0]   short_len;
	logic [MS_W-1:0]   long_len;
	logic [SET_W-1:0]  set_len;
	logic [CODE_W-1:0] ph;
	logic              paused;
	logic              long_brk;
	logic [MS_W-1:0]   length_ms;
	logic [MS_W-1:0]   left_ms;
	logic [SET_W-1:0]  set_pos;
	logic [DAY_W-1:0]  day_cnt;

	timer_view_t status_due[$];

	int unsigned in_gap_max = 0;
	int unsigned out_gap_max = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned beats_taken = 0;
	int unsigned beats_stalled_for = 0;
	int unsigned stall_left = 0;

	focus_break_cycle_timer dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.command           (command),
		.elapsed_ms        (elapsed_ms),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.phase_now         (phase_now),
		.is_paused         (is_paused),
		.is_long_break     (is_long_break),
		.remaining_ms      (remaining_ms),
		.remaining_seconds (remaining_seconds),
		.duration_ms       (duration_ms),
		.set_position      (set_position),
		.sessions_today    (sessions_today),
		.session_ended     (session_ended)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic note_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (mismatch_count < PRINT_LIMIT)
			$display("mismatch at cycle %0d: %s got %0d expected %0d",
				cycle_count, what, got, want);
		mismatch_count++;
	endtask

	// ---------------- model ----------------

	task automatic back_to_idle();
		ph = CODE_IDLE;
		paused = 1'b0;
		length_ms = focus_len;
		left_ms = focus_len;
	endtask

	task automatic end_break();
		if (long_brk) begin
			set_pos = '0;
			long_brk = 1'b0;
		end
		back_to_idle();
	endtask

	task automatic advance_timer(input logic [CMD_W-1:0] cmd, input logic [TICK_W-1:0] ms);
		timer_view_t v;
		logic        ended;
		logic [31:0] secs;
		ended = 1'b0;
		case (cmd)
			CMD_TICK: begin
				if (ph != CODE_IDLE && !paused) begin
					if (left_ms <= {{(MS_W-TICK_W){1'b0}}, ms}) begin
						ended = 1'b1;
						if (ph == CODE_FOCUS) begin
							if (day_cnt != DAY_MAX) day_cnt++;
							if (set_pos != SET_MAX) set_pos++;
							long_brk = (set_pos >= set_len);
							ph = CODE_BREAK;
							paused = 1'b0;
							length_ms = long_brk ? long_len : short_len;
							left_ms = length_ms;
						end else begin
							end_break();
						end
					end else begin
						left_ms = left_ms - {{(MS_W-TICK_W){1'b0}}, ms};
					end
				end
			end
			CMD_TAP: begin
				if (ph == CODE_IDLE) begin
					ph = CODE_FOCUS;
					paused = 1'b0;
				end else begin
					paused = !paused;
				end
			end
			CMD_SKIP: begin
				if (ph == CODE_FOCUS) back_to_idle();
				else if (ph == CODE_BREAK) end_break();
			end
			CMD_RESET: begin
				left_ms = length_ms;
				if (ph != CODE_IDLE) paused = 1'b1;
			end
			CMD_CLEAR: day_cnt = '0;
			default: ;
		endcase
		secs = ({8'd0, left_ms} + 32'd999) / 32'd1000;
		v.phase = ph;
		v.paused = paused;
		v.long_brk = long_brk;
		v.left_ms = left_ms;
		v.left_sec = secs[SEC_W-1:0];
		v.length_ms = length_ms;
		v.set_pos = set_pos;
		v.day_cnt = day_cnt;
		v.ended = ended;
		status_due.push_back(v);
	endtask

	// ---------------- drivers ----------------

	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [TICK_W-1:0] ms);
		int unsigned gap;
		gap = $urandom_range(0, in_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		elapsed_ms <= ms;
		do @(posedge clk); while (in_stall);
		advance_timer(cmd, ms);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_FOCUS: focus_len = value;
			REG_SHORT: short_len = value;
			REG_LONG:  long_len = value;
			REG_SETS:  set_len = value[SET_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_lengths(input logic [MS_W-1:0] f, input logic [MS_W-1:0] s,
		input logic [MS_W-1:0] l, input logic [SET_W-1:0] n);
		write_reg(REG_FOCUS, f);
		write_reg(REG_SHORT, s);
		write_reg(REG_LONG, l);
		write_reg(REG_SETS, {{(MS_W-SET_W){1'b0}}, n});
	endtask

	// drop valid, then wait for every result and the pipeline to empty
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (status_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_random_items(input int unsigned n, input int unsigned ms_max);
		logic [CMD_W-1:0]  cmd;
		logic [TICK_W-1:0] ms;
		int unsigned       r;
		int unsigned       k;
		for (int unsigned i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			k = $urandom_range(0, 99);
			// mostly keep the timer running so phases actually expire
			if (ph == CODE_IDLE && r < 40) cmd = CMD_TAP;
			else if (paused && r < 30) cmd = CMD_TAP;
			else if (r < 72) cmd = CMD_TICK;
			else if (r < 80) cmd = CMD_TAP;
			else if (r < 86) cmd = CMD_SKIP;
			else if (r < 91) cmd = CMD_RESET;
			else if (r < 95) cmd = CMD_CLEAR;
			else cmd = CMD_W'($urandom_range(5, 7));
			if (k < 5) ms = '0;
			else if (k < 10) ms = '1;
			else if (k < 20 || cmd != CMD_TICK) ms = TICK_W'($urandom);
			else ms = TICK_W'($urandom_range(0, ms_max));
			send_command(cmd, ms);
		end
	endtask

	// ---------------- tests ----------------

	task automatic test_commands_at_reset();
		in_gap_max = 3;
		out_gap_max = 3;
		send_command(CMD_TICK, 16'hFFFF);
		send_command(CMD_W'(5), 16'h5555);
		send_command(CMD_W'(6), 16'hAAAA);
		send_command(CMD_W'(7), 16'h0000);
		send_command(CMD_RESET, 16'd0);
		send_command(CMD_TAP, 16'd0);
		send_command(CMD_TICK, 16'd0);
		send_command(CMD_TICK, 16'hFFFF);
		send_command(CMD_TICK, 16'd1234);
		send_command(CMD_RESET, 16'd0);
		send_command(CMD_TICK, 16'd1000);
		send_command(CMD_TAP, 16'd0);
		send_command(CMD_TAP, 16'd0);
		send_command(CMD_TAP, 16'd0);
		send_command(CMD_SKIP, 16'd0);
		send_command(CMD_CLEAR, 16'd0);
	endtask

	// zero lengths expire on a zero tick; zero sessions per set means long breaks
	task automatic test_zero_lengths();
		settle();
		set_lengths(24'd0, 24'd0, 24'd5000, 4'd0);
		send_command(CMD_TAP, 16'd0);
		send_command(CMD_TICK, 16'd0);
		send_command(CMD_TAP, 16'd0);
		send_command(CMD_TAP, 16'd0);
		send_command(CMD_TICK, 16'd4000);
		send_command(CMD_RESET, 16'd0);
		send_command(CMD_TAP, 16'd0);
		send_command(CMD_SKIP, 16'd0);
		send_command(CMD_SKIP, 16'd0);
	endtask

	task automatic test_short_cycles();
		settle();
		set_lengths(24'd2000, 24'd500, 24'd1500, 4'd2);
		in_gap_max = 8;
		out_gap_max = 8;
		run_random_items(200, 1200);
	endtask

	// one-millisecond phases, full set of fifteen before the long break
	task automatic test_full_set();
		settle();
		set_lengths(24'd1, 24'd1, 24'd1, 4'd15);
		in_gap_max = 0;
		out_gap_max = 0;
		run_random_items(200, 3);
	endtask

	task automatic test_random_lengths();
		for (int p = 0; p < 3; p++) begin
			settle();
			set_lengths(MS_W'($urandom_range(1, 20000)), MS_W'($urandom_range(1, 20000)),
				MS_W'($urandom_range(1, 20000)), SET_W'($urandom_range(0, 15)));
			in_gap_max = (p == 1) ? 0 : 8;
			out_gap_max = (p == 2) ? 0 : 8;
			run_random_items(100, 10000);
		end
	endtask

	task automatic test_longest_lengths();
		settle();
		set_lengths(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 4'd1);
		in_gap_max = 8;
		out_gap_max = 8;
		run_random_items(300, 65535);
		settle();
		set_lengths(RST_FOCUS_MS, RST_SHORT_MS, RST_LONG_MS, RST_SETS);
		run_random_items(50, 65535);
	endtask

	// tap, expire focus, expire break back to back with zero lengths
	task automatic test_rapid_sessions();
		settle();
		set_lengths(24'd0, 24'd0, 24'd0, 4'd0);
		in_gap_max = 0;
		out_gap_max = 0;
		send_command(CMD_CLEAR, 16'd0);
		for (int i = 0; i < 20; i++) begin
			send_command(CMD_TAP, TICK_W'($urandom));
			send_command(CMD_TICK, TICK_W'($urandom));
			send_command(CMD_TICK, TICK_W'($urandom));
		end
		send_command(CMD_CLEAR, 16'd0);
	endtask

	// ---------------- result side ----------------

	// after each result beat hold stall for a random number of cycles
	always @(negedge clk) begin
		if (beats_taken != beats_stalled_for) begin
			beats_stalled_for = beats_taken;
			stall_left = $urandom_range(0, out_gap_max);
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_beat
		timer_view_t want;
		if (arst_n && out_valid && !out_stall) begin
			beats_taken++;
			if (status_due.size() == 0) begin
				note_mismatch("result with nothing expected", 32'd1, 32'd0);
			end else begin
				want = status_due.pop_front();
				if (phase_now !== want.phase)
					note_mismatch("phase_now", 32'(phase_now), 32'(want.phase));
				if (is_paused !== want.paused)
					note_mismatch("is_paused", 32'(is_paused), 32'(want.paused));
				if (is_long_break !== want.long_brk)
					note_mismatch("is_long_break", 32'(is_long_break),
						32'(want.long_brk));
				if (remaining_ms !== want.left_ms)
					note_mismatch("remaining_ms", 32'(remaining_ms), 32'(want.left_ms));
				if (remaining_seconds !== want.left_sec)
					note_mismatch("remaining_seconds", 32'(remaining_seconds),
						32'(want.left_sec));
				if (duration_ms !== want.length_ms)
					note_mismatch("duration_ms", 32'(duration_ms), 32'(want.length_ms));
				if (set_position !== want.set_pos)
					note_mismatch("set_position", 32'(set_position), 32'(want.set_pos));
				if (sessions_today !== want.day_cnt)
					note_mismatch("sessions_today", 32'(sessions_today),
						32'(want.day_cnt));
				if (session_ended !== want.ended)
					note_mismatch("session_ended", 32'(session_ended), 32'(want.ended));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		command = '0;
		elapsed_ms = '0;
		focus_len = RST_FOCUS_MS;
		short_len = RST_SHORT_MS;
		long_len = RST_LONG_MS;
		set_len = RST_SETS;
		ph = CODE_IDLE;
		paused = 1'b0;
		long_brk = 1'b0;
		length_ms = RST_FOCUS_MS;
		left_ms = RST_FOCUS_MS;
		set_pos = '0;
		day_cnt = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_commands_at_reset();
		test_zero_lengths();
		test_short_cycles();
		test_full_set();
		test_random_lengths();
		test_longest_lengths();
		test_rapid_sessions();

		settle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && status_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/fbct_pkg.sv
hw/rtl/fbct_core.sv
hw/rtl/fbct_out_stage.sv
hw/rtl/focus_break_cycle_timer.sv
tb/testbench.sv
